// ===== rtl/core/affine_pixel_transform_composer_macros.svh =====
// Assertion macros for the affine pixel transform composer.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef AFFINE_PIXEL_TRANSFORM_COMPOSER_MACROS_SVH
`define AFFINE_PIXEL_TRANSFORM_COMPOSER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define APT_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("affine pixel transform composer: assertion failed");
`define APT_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("affine pixel transform composer: assertion failed");
`else
`define APT_ASSERT_SAME(label, clock, reset, ante, cons)
`define APT_ASSERT_NEXT(label, clock, reset, ante, cons)
`endif
`endif

// ===== rtl/core/apt_pkg.sv =====
// Shared types and constants for the affine pixel transform composer.
// No dependencies; used by affine_pixel_transform_composer.
package apt_pkg;

  localparam int POS_BITS           = 12;
  localparam int COLOR_BITS         = 24;
  localparam int AMOUNT_BITS        = 17;
  localparam int FRAME_BITS         = 13;
  localparam int TRANS_BITS         = 32;
  localparam int DEFAULT_COORD_BITS = 12;

  localparam logic [FRAME_BITS-1:0] FRAME_RESET = 13'd512;

  // Configuration register indexes.
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    MODE_UP         = 4'd0,
    MODE_LEFT       = 4'd1,
    MODE_DOWN       = 4'd2,
    MODE_RIGHT      = 4'd3,
    MODE_ROT_CW     = 4'd4,
    MODE_ROT_CCW    = 4'd5,
    MODE_MIRROR_ROW = 4'd6,
    MODE_MIRROR_COL = 4'd7,
    MODE_START      = 4'd8,
    MODE_MAP        = 4'd9
  } mode_t;

  // One entry of the linear part, always -1, 0 or +1.
  typedef logic signed [1:0] coef_t;

  localparam coef_t COEF_ZERO = 2'sb00;
  localparam coef_t COEF_POS  = 2'sb01;
  localparam coef_t COEF_NEG  = 2'sb11;

endpackage

// ===== rtl/core/affine_pixel_transform_composer.sv =====
// A map-pixel request's result is registered in the result register, or parked in the skid register while that is held.
// Throughput: one request per cycle; item_ready drops only while both the result
// register and the skid register hold results that the sink has not taken.
// Other requests update the transform in the cycle they are accepted.
// Reset (rst, synchronous): identity transform, zero translation, 512 x 512 frame.
// Depends on apt_pkg and affine_pixel_transform_composer_macros.svh.
`include "affine_pixel_transform_composer_macros.svh"

module affine_pixel_transform_composer #(
  parameter int COORD_BITS = apt_pkg::DEFAULT_COORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [apt_pkg::FRAME_BITS-1:0]      cfg_data,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [3:0]                          mode,
  input  logic signed [apt_pkg::AMOUNT_BITS-1:0] amount,
  input  logic [apt_pkg::POS_BITS-1:0]        pixel_row,
  input  logic [apt_pkg::POS_BITS-1:0]        pixel_col,
  input  logic [apt_pkg::COLOR_BITS-1:0]      pixel_color,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [apt_pkg::POS_BITS-1:0]        new_row,
  output logic [apt_pkg::POS_BITS-1:0]        new_col,
  output logic [apt_pkg::COLOR_BITS-1:0]      out_color,
  output logic                                off_frame
);

  // Only the low bits that both the port and COORD_BITS allow take part.
  localparam int USE_BITS = (COORD_BITS < apt_pkg::POS_BITS) ? COORD_BITS : apt_pkg::POS_BITS;
  localparam logic [apt_pkg::POS_BITS-1:0] COORD_MASK =
    apt_pkg::POS_BITS'(((apt_pkg::POS_BITS + 1)'(1) << USE_BITS) - (apt_pkg::POS_BITS + 1)'(1));
  localparam int SUM_BITS = apt_pkg::TRANS_BITS + 2;

  function automatic logic signed [SUM_BITS-1:0] scale(
    input apt_pkg::coef_t          k,
    input logic [apt_pkg::POS_BITS-1:0] v
  );
    logic signed [SUM_BITS-1:0] ext;
    ext = $signed({{(SUM_BITS - apt_pkg::POS_BITS){1'b0}}, v});
    case (k)
      apt_pkg::COEF_POS: scale = ext;
      apt_pkg::COEF_NEG: scale = -ext;
      default:           scale = '0;
    endcase
  endfunction

  // Transform state and frame size.
  apt_pkg::coef_t lin [4];
  apt_pkg::coef_t lin_next [4];
  logic [apt_pkg::TRANS_BITS-1:0] tr, tr_next;
  logic [apt_pkg::TRANS_BITS-1:0] tc, tc_next;
  logic [apt_pkg::FRAME_BITS-1:0] frame_width, frame_height;

  // Result register and skid register.
  logic                           skid_valid;
  logic [apt_pkg::POS_BITS-1:0]   skid_row, skid_col;
  logic [apt_pkg::COLOR_BITS-1:0] skid_color;
  logic                           skid_off;

  logic                           item_fire, result_fire, map_fire;
  apt_pkg::mode_t                 op;
  logic [1:0]                     quarter;
  logic [apt_pkg::TRANS_BITS-1:0] amt_ext, width_m1, height_m1;
  logic [apt_pkg::POS_BITS-1:0]   r_in, c_in;
  logic signed [SUM_BITS-1:0]     nr, nc;
  logic                           off_calc;

  assign cfg_ready   = 1'b1;
  assign item_ready  = !skid_valid;
  assign item_fire   = item_valid && item_ready;
  assign result_fire = result_valid && result_ready;
  assign op          = apt_pkg::mode_t'(mode);
  assign map_fire    = item_fire && (op == apt_pkg::MODE_MAP);

  assign amt_ext   = apt_pkg::TRANS_BITS'(amount);
  assign width_m1  = apt_pkg::TRANS_BITS'(frame_width) - apt_pkg::TRANS_BITS'(1);
  assign height_m1 = apt_pkg::TRANS_BITS'(frame_height) - apt_pkg::TRANS_BITS'(1);

  // Pixel mapping with the transform as it stands before this request.
  assign r_in = pixel_row & COORD_MASK;
  assign c_in = pixel_col & COORD_MASK;
  assign nr = scale(lin[0], r_in) + scale(lin[1], c_in) + SUM_BITS'($signed(tr));
  assign nc = scale(lin[2], r_in) + scale(lin[3], c_in) + SUM_BITS'($signed(tc));
  assign off_calc = nr[SUM_BITS-1] || (nr >= $signed(SUM_BITS'(frame_height))) ||
                    nc[SUM_BITS-1] || (nc >= $signed(SUM_BITS'(frame_width)));

  // Composition of the next transform.
  always_comb begin
    quarter = 2'd0;
    for (int i = 0; i < 4; i++) begin
      lin_next[i] = lin[i];
    end
    tr_next = tr;
    tc_next = tc;
    if (item_fire) begin
      case (op)
        apt_pkg::MODE_UP:    tr_next = tr - amt_ext;
        apt_pkg::MODE_LEFT:  tc_next = tc - amt_ext;
        apt_pkg::MODE_DOWN:  tr_next = tr + amt_ext;
        apt_pkg::MODE_RIGHT: tc_next = tc + amt_ext;
        apt_pkg::MODE_ROT_CW, apt_pkg::MODE_ROT_CCW: begin
          quarter = (op == apt_pkg::MODE_ROT_CW) ? amount[1:0] : 2'd0 - amount[1:0];
          case (quarter)
            2'd1: begin
              lin_next[0] = lin[2];
              lin_next[1] = lin[3];
              lin_next[2] = -lin[0];
              lin_next[3] = -lin[1];
              tr_next = tc;
              tc_next = width_m1 - tr;
            end
            2'd2: begin
              lin_next[0] = -lin[0];
              lin_next[1] = -lin[1];
              lin_next[2] = -lin[2];
              lin_next[3] = -lin[3];
              tr_next = width_m1 - tr;
              tc_next = width_m1 - tc;
            end
            2'd3: begin
              lin_next[0] = -lin[2];
              lin_next[1] = -lin[3];
              lin_next[2] = lin[0];
              lin_next[3] = lin[1];
              tr_next = width_m1 - tc;
              tc_next = tr;
            end
            default: begin
            end
          endcase
        end
        apt_pkg::MODE_MIRROR_ROW: begin
          lin_next[0] = -lin[0];
          lin_next[1] = -lin[1];
          tr_next = height_m1 - tr;
        end
        apt_pkg::MODE_MIRROR_COL: begin
          lin_next[2] = -lin[2];
          lin_next[3] = -lin[3];
          tc_next = width_m1 - tc;
        end
        apt_pkg::MODE_START: begin
          lin_next[0] = apt_pkg::COEF_POS;
          lin_next[1] = apt_pkg::COEF_ZERO;
          lin_next[2] = apt_pkg::COEF_ZERO;
          lin_next[3] = apt_pkg::COEF_POS;
          tr_next = '0;
          tc_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lin[0]       <= apt_pkg::COEF_POS;
      lin[1]       <= apt_pkg::COEF_ZERO;
      lin[2]       <= apt_pkg::COEF_ZERO;
      lin[3]       <= apt_pkg::COEF_POS;
      tr           <= '0;
      tc           <= '0;
      frame_width  <= apt_pkg::FRAME_RESET;
      frame_height <= apt_pkg::FRAME_RESET;
    end else begin
      for (int i = 0; i < 4; i++) begin
        lin[i] <= lin_next[i];
      end
      tr <= tr_next;
      tc <= tc_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == apt_pkg::CFG_FRAME_WIDTH) begin
          frame_width <= cfg_data;
        end
        if (cfg_index == apt_pkg::CFG_FRAME_HEIGHT) begin
          frame_height <= cfg_data;
        end
      end
    end
  end

  // Output control: a new result goes to the result register when it is free
  // or being emptied, otherwise it parks in the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (result_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (map_fire) begin
      if (!result_valid || result_fire) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (result_fire) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result_fire) begin
        new_row   <= skid_row;
        new_col   <= skid_col;
        out_color <= skid_color;
        off_frame <= skid_off;
      end
    end else if (map_fire) begin
      if (!result_valid || result_fire) begin
        new_row   <= nr[apt_pkg::POS_BITS-1:0] & COORD_MASK;
        new_col   <= nc[apt_pkg::POS_BITS-1:0] & COORD_MASK;
        out_color <= pixel_color;
        off_frame <= off_calc;
      end else begin
        skid_row   <= nr[apt_pkg::POS_BITS-1:0] & COORD_MASK;
        skid_col   <= nc[apt_pkg::POS_BITS-1:0] & COORD_MASK;
        skid_color <= pixel_color;
        skid_off   <= off_calc;
      end
    end
  end

  `APT_ASSERT_SAME(a_skid_behind_result, clk, rst, skid_valid, result_valid)
  `APT_ASSERT_NEXT(a_map_gives_result, clk, rst, map_fire && !result_valid, result_valid)
  `APT_ASSERT_NEXT(a_op_gives_none, clk, rst, item_fire && !map_fire && !result_valid, !result_valid)
  `APT_ASSERT_SAME(a_row_one_term, clk, rst, 1'b1, (lin[0] != apt_pkg::COEF_ZERO) != (lin[1] != apt_pkg::COEF_ZERO))
  `APT_ASSERT_SAME(a_col_one_term, clk, rst, 1'b1, (lin[2] != apt_pkg::COEF_ZERO) != (lin[3] != apt_pkg::COEF_ZERO))

endmodule
